>>> rtl/ndc_pkg.sv
// Shared constants and controller/datapath interface types for the non-prime divisor counter.
package ndc_pkg;

  localparam int MAX_N  = 65536;
  localparam int ADDR_W = $clog2(MAX_N);
  localparam int IDX_W  = ADDR_W + 1;
  localparam int NUM_W  = 16;
  localparam int CNT_W  = 8;

  typedef struct packed {
    logic clr_we;
    logic sieve_en;
    logic q_rd;
    logic out_load;
  } ndc_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic sieve_last;
  } ndc_stat_t;

endpackage

>>> rtl/ndc_datapath.sv
// Table memory, sieve walk counters and query result registers.
module ndc_datapath import ndc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  ndc_cmd_t         cmd,
  output ndc_stat_t        stat,
  input  logic [NUM_W-1:0] number,
  output logic [CNT_W-1:0] count,
  output logic             valid_res
);

  typedef struct packed {
    logic             comp;
    logic [CNT_W-1:0] cnt;
  } entry_t;

  entry_t mem [MAX_N];
  entry_t q;
  entry_t wr_data;
  logic   wr_en;
  logic   rd_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] i;
  logic [IDX_W-1:0]  j;
  logic [IDX_W-1:0]  j_sum;
  logic              j_fits;

  logic              wb_v;
  logic [ADDR_W-1:0] wb_addr;
  logic              wb_first;
  logic              prime;
  logic              prime_first;

  logic [31:0]       num_ext;
  logic [ADDR_W-1:0] num_addr;
  logic              num_ok;
  logic              q_inrange;

  assign num_ext  = 32'(number);
  assign num_addr = num_ext[ADDR_W-1:0];
  assign num_ok   = (number != '0) && (num_ext < 32'(MAX_N));

  assign j_sum  = j + IDX_W'(i);
  assign j_fits = j_sum < IDX_W'(MAX_N);

  assign stat.clr_last   = clr_addr == ADDR_W'(MAX_N - 1);
  assign stat.sieve_last = (i == ADDR_W'(MAX_N - 1)) && !j_fits;

  // first entry of a walk is i itself: its flag tells whether i is prime
  assign prime_first = !q.comp;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = '0;
    priority if (cmd.clr_we) begin
      wr_en        = 1'b1;
      wr_data.comp = 1'b0;
      wr_data.cnt  = (clr_addr == ADDR_W'(1)) ? CNT_W'(1) : CNT_W'(2);
    end else if (wb_v) begin
      wr_en   = 1'b1;
      wr_addr = wb_addr;
      if (wb_first) begin
        wr_data.comp = q.comp;
        wr_data.cnt  = prime_first ? (q.cnt - CNT_W'(1)) : q.cnt;
      end else begin
        wr_data.comp = 1'b1;
        wr_data.cnt  = prime ? q.cnt : (q.cnt + CNT_W'(1));
      end
    end else begin
      wr_en = 1'b0;
    end
  end

  assign rd_en   = cmd.sieve_en | cmd.q_rd;
  assign rd_addr = cmd.q_rd ? num_addr : j[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      i        <= ADDR_W'(2);
      j        <= IDX_W'(2);
      wb_v     <= 1'b0;
      prime    <= 1'b0;
    end else begin
      wb_v <= cmd.sieve_en;
      if (cmd.clr_we) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (cmd.sieve_en) begin
        if (j_fits) begin
          j <= j_sum;
        end else begin
          i <= i + ADDR_W'(1);
          j <= IDX_W'(i) + IDX_W'(1);
        end
      end
      if (wb_v && wb_first) begin
        prime <= prime_first;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sieve_en) begin
      wb_addr  <= j[ADDR_W-1:0];
      wb_first <= j == IDX_W'(i);
    end
    if (cmd.q_rd) begin
      q_inrange <= num_ok;
    end
    if (cmd.out_load) begin
      valid_res <= q_inrange;
      count     <= q_inrange ? q.cnt : '0;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (wb_v && cmd.sieve_en) |-> (wb_addr != j[ADDR_W-1:0]))
    else $error("sieve read hits the pending write-back address");

  a_query_after_build: assert property (@(posedge clk) disable iff (rst)
    cmd.q_rd |-> (!wb_v && !cmd.sieve_en && !cmd.clr_we))
    else $error("query read while table build still writes");

  a_clear_alone: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_we |-> (!wb_v && !cmd.sieve_en))
    else $error("fill pass overlaps the sieve walk");
`endif

endmodule

>>> rtl/ndc_ctrl.sv
// Build sequencer and query handshake control.
module ndc_ctrl import ndc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  ndc_stat_t stat,
  output ndc_cmd_t  cmd,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_SIEVE = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_READY = 4'b1000
  } ndc_state_t;

  ndc_state_t state;
  ndc_state_t state_next;
  logic       s1_v;
  logic       accept;
  logic       adv;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (stat.clr_last) state_next = ST_SIEVE;
      ST_SIEVE: if (stat.sieve_last) state_next = ST_FLUSH;
      ST_FLUSH: state_next = ST_READY;
      ST_READY: state_next = ST_READY;
      default:  state_next = ST_CLEAR;
    endcase
  end

  assign adv      = s1_v && !(out_valid && out_stall);
  assign in_stall = (state != ST_READY) || (s1_v && out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  assign cmd.clr_we   = state == ST_CLEAR;
  assign cmd.sieve_en = state == ST_SIEVE;
  assign cmd.q_rd     = accept;
  assign cmd.out_load = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      s1_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        s1_v <= 1'b1;
      end else if (adv) begin
        s1_v <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_sticks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READY) |=> (state == ST_READY))
    else $error("left ready state after build");

  a_pending_kept: assert property (@(posedge clk) disable iff (rst)
    (s1_v && out_valid && out_stall) |=> s1_v)
    else $error("in-flight lookup dropped under output stall");

  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_v))
    else $error("result shown without a lookup in flight");
`endif

endmodule

>>> rtl/non_prime_divisor_count_core.sv
// Top level of the non-prime divisor counter: table build and query lookup.
//
//   channel  signals                   direction  payload
//   in       in_valid / in_stall       to core    number[15:0]
//   out      out_valid / out_stall     from core  count[7:0], valid_res
//
// After reset the core fills one table of {composite flag, count} over
// 0..MAX_N-1: a fill pass that writes all MAX_N entries, then a sieve walk
// that visits every multiple j = i, 2i, ... below MAX_N for each i in
// 2..MAX_N-1, one memory read-modify-write per cycle, then a flush state.
// in_stall stays high throughout. Then one query is taken per cycle unless
// a stalled output blocks the lookup: the single table read port sets that
// figure. A result goes from the table read register to the output registers.
// A stalled output holds one result while one more lookup waits behind it.
module non_prime_divisor_count_core import ndc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [NUM_W-1:0] number,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CNT_W-1:0] count,
  output logic             valid_res
);

  ndc_cmd_t  cmd;
  ndc_stat_t stat;

  // Sequence the build, then run the query handshake.
  ndc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .stat      (stat),
    .cmd       (cmd),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  // Hold the table; composite i adds one to each proper multiple, prime i
  // drops its own entry by one and only marks its multiples composite.
  ndc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .number    (number),
    .count     (count),
    .valid_res (valid_res)
  );

endmodule
